// ----- src/csi_pkg.sv -----
// Shared constants for the cubic segment interpolator: curve mode codes.
package csi_pkg;

    // Width of the curve mode register
    localparam int MODE_W = 2;

    // Curve mode codes; the spare code evaluates the Bezier form
    localparam logic [MODE_W-1:0] MODE_TANGENT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_XFORM   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BEZIER  = 2'd2;

endpackage

// ----- src/csi_coef.sv -----
// Entry stage: clamps the position and forms the doubled cubic coefficients.
module csi_coef #(
    parameter int SAMPLE_W = 16,
    parameter int FRAC_W   = 16,
    parameter int COEF_W   = SAMPLE_W + 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [csi_pkg::MODE_W-1:0]    i_mode,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [FRAC_W:0]               i_frac_pos,
    input  logic signed [SAMPLE_W-1:0]    i_start_value,
    input  logic signed [SAMPLE_W-1:0]    i_first_aux,
    input  logic signed [SAMPLE_W-1:0]    i_second_aux,
    input  logic signed [SAMPLE_W-1:0]    i_end_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [FRAC_W:0]               o_x,
    output logic signed [COEF_W-1:0]      o_c3,
    output logic [3*COEF_W-1:0]           o_coefs
);

    localparam int EXT_W = COEF_W - SAMPLE_W;

    logic signed [COEF_W-1:0] y0, pa, pb, y1, d;
    logic signed [COEF_W-1:0] cc, vv, ww, aa;
    logic signed [COEF_W-1:0] n_c0, n_c1, n_c2, n_c3;
    logic [FRAC_W:0]          n_x;
    logic                     en;

    logic                     r_valid;
    logic [FRAC_W:0]          r_x;
    logic signed [COEF_W-1:0] r_c0, r_c1, r_c2, r_c3;

    // Widen the samples so no intermediate can overflow
    assign y0 = {{EXT_W{i_start_value[SAMPLE_W-1]}}, i_start_value};
    assign pa = {{EXT_W{i_first_aux[SAMPLE_W-1]}}, i_first_aux};
    assign pb = {{EXT_W{i_second_aux[SAMPLE_W-1]}}, i_second_aux};
    assign y1 = {{EXT_W{i_end_value[SAMPLE_W-1]}}, i_end_value};
    assign d  = y1 - y0;

    // x-form helper terms
    assign cc = y1 - pa;
    assign vv = (y0 - y1) <<< 1;
    assign ww = cc + vv;
    assign aa = ww + vv + (pb - y0);

    // Position above one is clamped to exactly one
    assign n_x = i_frac_pos[FRAC_W] ? {1'b1, {FRAC_W{1'b0}}} : i_frac_pos;

    // Coefficients, all scaled by two so the x-form halves stay integer
    always_comb begin
        n_c0 = y0 <<< 1;
        case (i_mode)
            csi_pkg::MODE_TANGENT: begin
                n_c1 = pa <<< 1;
                n_c2 = ((d <<< 1) + d - (pa <<< 1) + pb) <<< 1;
                n_c3 = (pa - pb - (d <<< 1)) <<< 1;
            end
            csi_pkg::MODE_XFORM: begin
                n_c1 = cc;
                n_c2 = -(ww + aa);
                n_c3 = aa;
            end
            default: begin
                // Bezier, also for the spare code
                n_c1 = (((pa - y0) <<< 1) + (pa - y0)) <<< 1;
                n_c2 = (((y0 - (pa <<< 1) + pb) <<< 1) + (y0 - (pa <<< 1) + pb)) <<< 1;
                n_c3 = (d + ((pa - pb) <<< 1) + (pa - pb)) <<< 1;
            end
        endcase
    end

    // Stage handshake
    assign en      = !r_valid || !i_stall;
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_x  <= n_x;
            r_c0 <= n_c0;
            r_c1 <= n_c1;
            r_c2 <= n_c2;
            r_c3 <= n_c3;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_c3    = r_c3;
    assign o_coefs = {r_c2, r_c1, r_c0};

endmodule

// ----- src/csi_horner_cell.sv -----
// One Horner step cell: acc * x + coef * 2^SHIFT, split into two registered halves.
module csi_horner_cell #(
    parameter int FRAC_W   = 16,
    parameter int COEF_W   = 22,
    parameter int IN_W     = 22,
    parameter int COEF_IDX = 2,
    parameter int SHIFT    = 16,
    parameter int OUT_W    = IN_W + FRAC_W + 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [IN_W-1:0]     i_acc,
    input  logic [FRAC_W:0]            i_x,
    input  logic [3*COEF_W-1:0]        i_coefs,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [OUT_W-1:0]    o_acc,
    output logic [FRAC_W:0]            o_x,
    output logic [3*COEF_W-1:0]        o_coefs
);

    localparam int LO_W  = IN_W / 2;
    localparam int HI_W  = IN_W - LO_W;
    localparam int PL_W  = LO_W + FRAC_W + 1;
    localparam int PH_W  = HI_W + FRAC_W + 2;
    localparam int CPAD  = OUT_W - COEF_W - SHIFT;

    logic [LO_W-1:0]          acc_lo;
    logic signed [HI_W-1:0]   acc_hi;
    logic [PL_W-1:0]          n_plo;
    logic signed [PH_W-1:0]   n_phi;
    logic signed [COEF_W-1:0] coef;
    logic signed [OUT_W-1:0]  t_hi, t_lo, t_c, n_acc;
    logic                     en_a, en_b;

    logic                     r_va, r_vb;
    logic [PL_W-1:0]          r_plo;
    logic signed [PH_W-1:0]   r_phi;
    logic [FRAC_W:0]          r_xa, r_xb;
    logic [3*COEF_W-1:0]      r_ca, r_cb;
    logic signed [OUT_W-1:0]  r_acc;

    // Half-width partial products
    assign acc_lo = i_acc[LO_W-1:0];
    assign acc_hi = i_acc[IN_W-1:LO_W];
    assign n_plo  = {{(FRAC_W+1){1'b0}}, acc_lo} * {{LO_W{1'b0}}, i_x};
    assign n_phi  = $signed({{(FRAC_W+2){acc_hi[HI_W-1]}}, acc_hi})
                  * $signed({{HI_W{1'b0}}, 1'b0, i_x});

    // Recombine and add the scaled coefficient
    assign coef  = r_ca[COEF_IDX*COEF_W +: COEF_W];
    assign t_hi  = {r_phi, {LO_W{1'b0}}};
    assign t_lo  = {{(OUT_W-PL_W){1'b0}}, r_plo};
    assign t_c   = {{CPAD{coef[COEF_W-1]}}, coef, {SHIFT{1'b0}}};
    assign n_acc = t_hi + t_lo + t_c;

    // Two-stage handshake, bubbles collapse
    assign en_b    = !r_vb || !i_stall;
    assign en_a    = !r_va || en_b;
    assign o_stall = r_va && !en_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
        end
    end

    // Product stage
    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_plo <= n_plo;
            r_phi <= n_phi;
            r_xa  <= i_x;
            r_ca  <= i_coefs;
        end
    end

    // Sum stage
    always_ff @(posedge i_clk) begin
        if (en_b && r_va) begin
            r_acc <= n_acc;
            r_xb  <= r_xa;
            r_cb  <= r_ca;
        end
    end

    assign o_valid = r_vb;
    assign o_acc   = r_acc;
    assign o_x     = r_xb;
    assign o_coefs = r_cb;

endmodule

// ----- src/csi_round.sv -----
// Output stage: round to nearest, saturate and hold the result for transfer.
module csi_round #(
    parameter int SAMPLE_W = 16,
    parameter int FRAC_W   = 16,
    parameter int IN_W     = 76
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [IN_W-1:0]      i_acc,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [SAMPLE_W-1:0]  o_value,
    output logic                        o_sat
);

    localparam int SH    = 3 * FRAC_W + 1;
    localparam int SUM_W = IN_W + 1;
    localparam int R_W   = SUM_W - SH;
    localparam logic signed [SUM_W-1:0] HALF  = SUM_W'(1) << (SH - 1);
    localparam logic signed [R_W-1:0]   LIM_H = {{(R_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [R_W-1:0]   LIM_L = {{(R_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

    logic signed [SUM_W-1:0]    sum;
    logic signed [R_W-1:0]      rnd;
    logic                       over, under, en;
    logic signed [SAMPLE_W-1:0] n_value;

    logic                       r_valid;
    logic signed [SAMPLE_W-1:0] r_value;
    logic                       r_sat;

    // Add one half and drop the fraction; ties go up
    assign sum   = {i_acc[IN_W-1], i_acc} + HALF;
    assign rnd   = sum[SUM_W-1:SH];
    assign over  = rnd > LIM_H;
    assign under = rnd < LIM_L;

    always_comb begin
        if (over) begin
            n_value = LIM_H[SAMPLE_W-1:0];
        end else if (under) begin
            n_value = LIM_L[SAMPLE_W-1:0];
        end else begin
            n_value = rnd[SAMPLE_W-1:0];
        end
    end

    // Output register handshake
    assign en      = !r_valid || !i_stall;
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_value <= n_value;
            r_sat   <= over || under;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_sat   = r_sat;

endmodule

// ----- src/cubic_segment_interpolator_unit.sv -----
// Top level of the cubic segment interpolator: coefficient stage, Horner chain, rounding.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one segment per transfer: position
//   i_frac_pos (unsigned Q1.FRAC_WIDTH, clamped to 1.0) and four signed samples.
//   Output channel (o_valid / i_stall) returns one rounded, saturated sample per
//   input, with o_saturated set when the value was clipped.
//   i_cfg_wr_en / i_cfg_wr_data write the curve mode: 0 tangent Hermite,
//   1 four-point x-form Hermite, 2 (and 3) cubic Bezier. Write it only when idle.
// Timing:
//   One coefficient stage, three Horner cells of two stages
//   each (split partial products, then recombine and add), one rounding stage.
//   Throughput is one item per cycle while no stall holds the output; every stage is registered.
// Reset:
//   i_rst_n low clears all pipeline valids and sets the mode to x-form Hermite.
// Back-pressure:
//   A stalled result holds at the outputs; empty stages behind it keep filling,
//   and o_stall rises only once every stage holds an item.
module cubic_segment_interpolator_unit #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_WIDTH   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [csi_pkg::MODE_W-1:0]       i_cfg_wr_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [FRAC_WIDTH:0]              i_frac_pos,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_start_value,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_first_aux,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_second_aux,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_end_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]   o_interp_value,
    output logic                             o_saturated
);

    localparam int CW = SAMPLE_WIDTH + 6;
    localparam int W0 = CW;
    localparam int W1 = W0 + FRAC_WIDTH + 2;
    localparam int W2 = W1 + FRAC_WIDTH + 2;
    localparam int W3 = W2 + FRAC_WIDTH + 2;

    logic [csi_pkg::MODE_W-1:0] r_curve_mode;

    logic                   v0, s0, v1, s1, v2, s2, v3, s3;
    logic [FRAC_WIDTH:0]    x0, x1, x2;
    logic signed [W0-1:0]   acc0;
    logic signed [W1-1:0]   acc1;
    logic signed [W2-1:0]   acc2;
    logic signed [W3-1:0]   acc3;
    logic [3*CW-1:0]        cf0, cf1, cf2;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_mode <= csi_pkg::MODE_XFORM;
        end else if (i_cfg_wr_en) begin
            r_curve_mode <= i_cfg_wr_data;
        end
    end

    // Coefficient stage
    csi_coef #(
        .SAMPLE_W (SAMPLE_WIDTH),
        .FRAC_W   (FRAC_WIDTH),
        .COEF_W   (CW)
    ) u_coef (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (r_curve_mode),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_frac_pos    (i_frac_pos),
        .i_start_value (i_start_value),
        .i_first_aux   (i_first_aux),
        .i_second_aux  (i_second_aux),
        .i_end_value   (i_end_value),
        .o_valid       (v0),
        .i_stall       (s0),
        .o_x           (x0),
        .o_c3          (acc0),
        .o_coefs       (cf0)
    );

    // Horner chain: c2, then c1, then c0
    csi_horner_cell #(
        .FRAC_W   (FRAC_WIDTH),
        .COEF_W   (CW),
        .IN_W     (W0),
        .COEF_IDX (2),
        .SHIFT    (FRAC_WIDTH),
        .OUT_W    (W1)
    ) u_cell1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v0),
        .o_stall (s0),
        .i_acc   (acc0),
        .i_x     (x0),
        .i_coefs (cf0),
        .o_valid (v1),
        .i_stall (s1),
        .o_acc   (acc1),
        .o_x     (x1),
        .o_coefs (cf1)
    );

    csi_horner_cell #(
        .FRAC_W   (FRAC_WIDTH),
        .COEF_W   (CW),
        .IN_W     (W1),
        .COEF_IDX (1),
        .SHIFT    (2 * FRAC_WIDTH),
        .OUT_W    (W2)
    ) u_cell2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .o_stall (s1),
        .i_acc   (acc1),
        .i_x     (x1),
        .i_coefs (cf1),
        .o_valid (v2),
        .i_stall (s2),
        .o_acc   (acc2),
        .o_x     (x2),
        .o_coefs (cf2)
    );

    csi_horner_cell #(
        .FRAC_W   (FRAC_WIDTH),
        .COEF_W   (CW),
        .IN_W     (W2),
        .COEF_IDX (0),
        .SHIFT    (3 * FRAC_WIDTH),
        .OUT_W    (W3)
    ) u_cell3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v2),
        .o_stall (s2),
        .i_acc   (acc2),
        .i_x     (x2),
        .i_coefs (cf2),
        .o_valid (v3),
        .i_stall (s3),
        .o_acc   (acc3),
        .o_x     (),
        .o_coefs ()
    );

    // Rounding and output register
    csi_round #(
        .SAMPLE_W (SAMPLE_WIDTH),
        .FRAC_W   (FRAC_WIDTH),
        .IN_W     (W3)
    ) u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v3),
        .o_stall (s3),
        .i_acc   (acc3),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_value (o_interp_value),
        .o_sat   (o_saturated)
    );

    // A saturated result sits on one of the two limits
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_interp_value == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} ||
             o_interp_value == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}))
        else $error("saturated result not at a limit");

    // Input is held off only while a finished result is blocked downstream
    a_stall_needs_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    // Pipeline is empty straight after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result present right after reset");

endmodule

// ----- dv/tb_cubic_segment_interpolator_unit.sv -----
// Self-checking testbench for the cubic segment interpolator with random handshake gaps.
module tb_cubic_segment_interpolator_unit;

    localparam int SAMPLE_W     = 16;
    localparam int FRAC_W       = 16;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 225;
    localparam int STRETCH      = 45;

    // Spare mode code, which the block treats as Bezier
    localparam logic [csi_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [csi_pkg::MODE_W-1:0] MODE_ORDER [8] = '{
        csi_pkg::MODE_TANGENT, csi_pkg::MODE_XFORM, csi_pkg::MODE_BEZIER, MODE_SPARE,
        csi_pkg::MODE_XFORM, csi_pkg::MODE_TANGENT, MODE_SPARE, csi_pkg::MODE_BEZIER};

    localparam logic [FRAC_W:0] FRAC_ONE   = 1 << FRAC_W;
    localparam logic [FRAC_W:0] FRAC_HALF  = 1 << (FRAC_W - 1);
    localparam logic [FRAC_W:0] FRAC_ABOVE = '1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam longint LIMIT_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint LIMIT_LO = -LIMIT_HI - 1;

    typedef struct {
        logic [FRAC_W:0]             frac_pos;
        logic signed [SAMPLE_W-1:0]  start_value;
        logic signed [SAMPLE_W-1:0]  first_aux;
        logic signed [SAMPLE_W-1:0]  second_aux;
        logic signed [SAMPLE_W-1:0]  end_value;
    } segment_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0]  interp_value;
        logic                        saturated;
    } sample_result_t;

    // DUT ports, all inputs driven to known values from time zero
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_wr_en = 1'b0;
    logic [csi_pkg::MODE_W-1:0]  i_cfg_wr_data = '0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [FRAC_W:0]             i_frac_pos = '0;
    logic signed [SAMPLE_W-1:0]  i_start_value = '0;
    logic signed [SAMPLE_W-1:0]  i_first_aux = '0;
    logic signed [SAMPLE_W-1:0]  i_second_aux = '0;
    logic signed [SAMPLE_W-1:0]  i_end_value = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]  o_interp_value;
    logic                        o_saturated;

    // Testbench state
    logic [csi_pkg::MODE_W-1:0] curve_mode = csi_pkg::MODE_XFORM;
    sample_result_t    expected_samples[$];
    int                error_count = 0;
    int                results_checked = 0;
    int                segments_sent = 0;
    int                mode_writes = 0;
    int                cycle_count = 0;
    bit                src_idle_on = 1'b1;
    bit                sink_idle_on = 1'b1;

    cubic_segment_interpolator_unit #(
        .SAMPLE_WIDTH(SAMPLE_W),
        .FRAC_WIDTH  (FRAC_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_frac_pos    (i_frac_pos),
        .i_start_value (i_start_value),
        .i_first_aux   (i_first_aux),
        .i_second_aux  (i_second_aux),
        .i_end_value   (i_end_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_interp_value(o_interp_value),
        .o_saturated   (o_saturated)
    );

    initial begin : clock_gen
        forever #2 i_clk = ~i_clk;
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("watchdog expired with %0d results outstanding", expected_samples.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Exact evaluation of one segment: coefficients are doubled to integers and
    // Horner runs wide, so the sum is 2*y(x) scaled by 2^(3*FRAC_W)
    function automatic sample_result_t interpolate_segment(segment_t seg,
                                                          logic [csi_pkg::MODE_W-1:0] mode);
        longint y0, pa, pb, y1, d, cc, vv, ww, aa, r;
        logic signed [127:0] k0, k1, k2, k3, x, acc, half;
        sample_result_t res;
        y0 = seg.start_value;
        pa = seg.first_aux;
        pb = seg.second_aux;
        y1 = seg.end_value;
        d  = y1 - y0;
        x  = (seg.frac_pos > FRAC_ONE) ? FRAC_ONE : seg.frac_pos;
        if (mode == csi_pkg::MODE_TANGENT) begin
            k0 = 2 * y0;
            k1 = 2 * pa;
            k2 = 2 * (3 * d - 2 * pa + pb);
            k3 = 2 * (pa - pb - 2 * d);
        end else if (mode == csi_pkg::MODE_XFORM) begin
            cc = y1 - pa;
            vv = 2 * (y0 - y1);
            ww = cc + vv;
            aa = ww + vv + (pb - y0);
            k0 = 2 * y0;
            k1 = cc;
            k2 = -(ww + aa);
            k3 = aa;
        end else begin
            // Bezier, also for the spare code
            k0 = 2 * y0;
            k1 = 2 * (3 * (pa - y0));
            k2 = 2 * (3 * (y0 - 2 * pa + pb));
            k3 = 2 * (d + 3 * (pa - pb));
        end
        acc  = k3;
        acc  = acc * x + (k2 <<< FRAC_W);
        acc  = acc * x + (k1 <<< (2 * FRAC_W));
        acc  = acc * x + (k0 <<< (3 * FRAC_W));
        half = 1;
        // Round half up, drop the doubling and the fraction scale
        acc  = (acc + (half <<< (3 * FRAC_W))) >>> (3 * FRAC_W + 1);
        r    = acc[63:0];
        res.saturated = 1'b0;
        if (r > LIMIT_HI) begin
            r = LIMIT_HI;
            res.saturated = 1'b1;
        end else if (r < LIMIT_LO) begin
            r = LIMIT_LO;
            res.saturated = 1'b1;
        end
        res.interp_value = SAMPLE_W'(r);
        return res;
    endfunction

    function automatic segment_t make_segment(logic [FRAC_W:0] frac,
                                              logic signed [SAMPLE_W-1:0] y0,
                                              logic signed [SAMPLE_W-1:0] a,
                                              logic signed [SAMPLE_W-1:0] b,
                                              logic signed [SAMPLE_W-1:0] y1);
        segment_t seg;
        seg.frac_pos    = frac;
        seg.start_value = y0;
        seg.first_aux   = a;
        seg.second_aux  = b;
        seg.end_value   = y1;
        return seg;
    endfunction

    // Samples lean on the rails and on values near zero
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            2: return SAMPLE_W'($urandom_range(0, 64) - 32);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Positions include both ends and codes above one
    function automatic logic [FRAC_W:0] rand_frac();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return FRAC_ONE;
            2: return (FRAC_W + 1)'($urandom_range(FRAC_ONE + 1, FRAC_ABOVE));
            default: return (FRAC_W + 1)'($urandom_range(0, FRAC_ONE));
        endcase
    endfunction

    function automatic segment_t rand_segment();
        return make_segment(rand_frac(), rand_sample(), rand_sample(), rand_sample(),
                            rand_sample());
    endfunction

    // One input transfer; entered and left just after a rising edge
    task automatic send_segment(segment_t seg);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_frac_pos    <= seg.frac_pos;
        i_start_value <= seg.start_value;
        i_first_aux   <= seg.first_aux;
        i_second_aux  <= seg.second_aux;
        i_end_value   <= seg.end_value;
        do @(posedge i_clk); while (o_stall);
        expected_samples.push_back(interpolate_segment(seg, curve_mode));
        segments_sent++;
    endtask

    // Stop sending and wait until every result is back and the pipe is empty
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_curve_mode(logic [csi_pkg::MODE_W-1:0] mode);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        curve_mode = mode;
        mode_writes++;
    endtask

    // Output side: random stall before each result transfer
    initial begin : sink_driver
        int hold;
        forever begin
            hold = sink_idle_on ? $urandom_range(0, 10) : 0;
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Compare each result transfer with the oldest prediction
    initial begin : result_checker
        sample_result_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (expected_samples.size() == 0) begin
                    $error("unexpected result: interp_value %0d saturated %0b",
                           o_interp_value, o_saturated);
                    error_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (o_interp_value !== want.interp_value) begin
                        $error("interp_value: expected %0d, actual %0d",
                               want.interp_value, o_interp_value);
                        error_count++;
                    end
                    if (o_saturated !== want.saturated) begin
                        $error("saturated: expected %0b, actual %0b",
                               want.saturated, o_saturated);
                        error_count++;
                    end
                    results_checked++;
                end
            end
        end
    end

    // Mode after reset is x-form Hermite, with no register write
    task automatic test_reset_default();
        send_segment(make_segment('0, rand_sample(), rand_sample(), rand_sample(),
                                  rand_sample()));
        send_segment(make_segment(FRAC_ONE, rand_sample(), rand_sample(), rand_sample(),
                                  rand_sample()));
        send_segment(make_segment(FRAC_HALF, rand_sample(), rand_sample(), rand_sample(),
                                  rand_sample()));
    endtask

    // Both ends of x, a position above one and rail samples, in every mode code
    task automatic test_mode_extremes();
        for (int i = 0; i < 4; i++) begin
            write_curve_mode(MODE_ORDER[i]);
            send_segment(make_segment('0, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
            send_segment(make_segment(FRAC_ONE, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                                      SAMPLE_MAX));
            send_segment(make_segment(FRAC_ABOVE, rand_sample(), rand_sample(),
                                      rand_sample(), rand_sample()));
            send_segment(make_segment(FRAC_HALF, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                                      SAMPLE_MAX));
        end
    endtask

    // Overshoot past both rails
    task automatic test_saturation();
        write_curve_mode(csi_pkg::MODE_TANGENT);
        send_segment(make_segment(FRAC_HALF, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN));
        write_curve_mode(csi_pkg::MODE_XFORM);
        send_segment(make_segment(FRAC_HALF, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX));
        send_segment(make_segment(FRAC_HALF, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN));
    endtask

    // Straight lines through +/-0.5: exact halves round upwards
    task automatic test_rounding_ties();
        write_curve_mode(csi_pkg::MODE_TANGENT);
        send_segment(make_segment(FRAC_HALF, 0, 1, -1, 1));
        send_segment(make_segment(FRAC_HALF, 0, -1, 1, -1));
    endtask

    // Random segments over a sequence of modes, idling redrawn in stretches
    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            write_curve_mode(MODE_ORDER[phase]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % STRETCH == 0) begin
                    src_idle_on  = ($urandom_range(0, 2) != 0);
                    sink_idle_on = ($urandom_range(0, 2) != 0);
                end
                send_segment(rand_segment());
            end
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin : test_sequence
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_default();
        test_mode_extremes();
        test_saturation();
        test_rounding_ties();
        test_random_traffic();
        wait_drained();
        $display("Run covered %0d segments in all four mode codes (%0d mode writes),",
                 segments_sent, mode_writes);
        $display("with %0d results checked under random gaps on both channels.",
                 results_checked);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
src/csi_pkg.sv
src/csi_coef.sv
src/csi_horner_cell.sv
src/csi_round.sv
src/cubic_segment_interpolator_unit.sv
dv/tb_cubic_segment_interpolator_unit.sv
